// File: hdl/frg_pkg.sv
// Shared types, codes and arithmetic helpers for the formation reference generator.
`default_nettype none
package frg_pkg;

  // Request kinds
  localparam logic [1:0] KIND_POSE   = 2'd0;
  localparam logic [1:0] KIND_TWIST  = 2'd1;
  localparam logic [1:0] KIND_OFFSET = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Configuration register indexes
  localparam logic REG_FOLLOWER_COUNT = 1'b0;
  localparam logic REG_LEADER_SLOT    = 1'b1;

  localparam logic [4:0] COUNT_RESET  = 5'd12;
  localparam logic [4:0] LEADER_NONE  = 5'b11111;
  localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

  // Micro-program layout
  localparam logic [4:0] STEP_TWIST_DONE = 5'd16;
  localparam logic [4:0] STEP_EMIT       = 5'd23;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         slot;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } req_t;

  typedef struct packed {
    logic [3:0]         follower;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [15:0] head_w;
    logic signed [15:0] head_x;
    logic signed [15:0] head_y;
    logic signed [15:0] head_z;
    logic               last;
  } res_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } offset_t;

  typedef enum logic [3:0] {
    A_V0, A_V1, A_V2, A_T0, A_T1, A_T2, A_L0, A_L1, A_L2
  } asel_e;

  typedef enum logic [2:0] {
    B_QW, B_QX, B_QY, B_QZ, B_R0, B_R1, B_R2
  } bsel_e;

  typedef enum logic [1:0] {
    OP_NOP, OP_LOAD, OP_ADD, OP_SUB
  } op_e;

  typedef enum logic [3:0] {
    WB_NONE, WB_T0, WB_T1, WB_T2, WB_R0, WB_R1, WB_R2, WB_C0, WB_C1, WB_C2
  } wb_e;

  typedef struct packed {
    asel_e a;
    bsel_e b;
    op_e   op;
    wb_e   wb;
  } uop_t;

  // Rotation t = 2(qv x v), v' = v + w t + qv x t, then rate x v'.
  // A write-back step stores the accumulator as it stood before this step.
  function automatic uop_t uop(input logic [4:0] step);
    uop_t u;
    u = '{A_V0, B_QW, OP_NOP, WB_NONE};
    case (step)
      5'd0:  u = '{A_V2, B_QY, OP_LOAD, WB_NONE};
      5'd1:  u = '{A_V1, B_QZ, OP_SUB,  WB_NONE};
      5'd2:  u = '{A_V0, B_QZ, OP_LOAD, WB_T0};
      5'd3:  u = '{A_V2, B_QX, OP_SUB,  WB_NONE};
      5'd4:  u = '{A_V1, B_QX, OP_LOAD, WB_T1};
      5'd5:  u = '{A_V0, B_QY, OP_SUB,  WB_NONE};
      5'd6:  u = '{A_T0, B_QW, OP_LOAD, WB_T2};
      5'd7:  u = '{A_T2, B_QY, OP_ADD,  WB_NONE};
      5'd8:  u = '{A_T1, B_QZ, OP_SUB,  WB_NONE};
      5'd9:  u = '{A_T1, B_QW, OP_LOAD, WB_R0};
      5'd10: u = '{A_T0, B_QZ, OP_ADD,  WB_NONE};
      5'd11: u = '{A_T2, B_QX, OP_SUB,  WB_NONE};
      5'd12: u = '{A_T2, B_QW, OP_LOAD, WB_R1};
      5'd13: u = '{A_T1, B_QX, OP_ADD,  WB_NONE};
      5'd14: u = '{A_T0, B_QY, OP_SUB,  WB_NONE};
      5'd15: u = '{A_V0, B_QW, OP_NOP,  WB_R2};
      5'd16: u = '{A_L2, B_R1, OP_LOAD, WB_NONE};
      5'd17: u = '{A_L1, B_R2, OP_SUB,  WB_NONE};
      5'd18: u = '{A_L0, B_R2, OP_LOAD, WB_C0};
      5'd19: u = '{A_L2, B_R0, OP_SUB,  WB_NONE};
      5'd20: u = '{A_L1, B_R0, OP_LOAD, WB_C1};
      5'd21: u = '{A_L0, B_R1, OP_SUB,  WB_NONE};
      5'd22: u = '{A_V0, B_QW, OP_NOP,  WB_C2};
      default: u = '{A_V0, B_QW, OP_NOP, WB_NONE};
    endcase
    return u;
  endfunction

  // Clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/frg_offset_mem.sv
// Formation offset store with grid defaults for slots never written.
`default_nettype none
module frg_offset_mem #(
  parameter int MAX_FOLLOWERS = 16,
  parameter int GRID_WIDTH    = 4,
  parameter int ROW_SPACING   = 131072,
  parameter int AW            = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire frg_pkg::offset_t wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output frg_pkg::offset_t      rd_data_o
);
  import frg_pkg::*;

  offset_t              mem [MAX_FOLLOWERS];
  offset_t              grid [MAX_FOLLOWERS];
  logic [MAX_FOLLOWERS-1:0] valid_q;
  offset_t              rd_mem_q;
  logic                 rd_valid_q;
  logic [AW-1:0]        rd_addr_q;

  // Reset grid, saturated at elaboration
  for (genvar i = 0; i < MAX_FOLLOWERS; i++) begin : g_grid
    localparam longint GX  = longint'(i % GRID_WIDTH) * longint'(ROW_SPACING);
    localparam longint GY  = longint'(i / GRID_WIDTH) * longint'(ROW_SPACING);
    localparam longint GXS = (GX > 64'sd2147483647) ? 64'sd2147483647 : GX;
    localparam longint GYS = (GY > 64'sd2147483647) ? 64'sd2147483647 : GY;
    assign grid[i].x = GXS[31:0];
    assign grid[i].y = GYS[31:0];
    assign grid[i].z = '0;
  end

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_mem_q <= mem[rd_addr_i];
  end

  // Written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
      rd_addr_q  <= rd_addr_i;
    end
  end

  assign rd_data_o = rd_valid_q ? rd_mem_q : grid[rd_addr_q];

endmodule
`default_nettype wire

// File: hdl/formation_reference_generator_unit.sv
// Top level: leader state, offset store and the shared multiply-accumulate sequencer.
// Pose and offset requests are taken while idle and busy stays low.
// A twist request holds busy while one rotation runs on the shared multiplier.
// A tick works through each processed slot in fetch, load and 24 multiplier steps,
// passes over a skipped slot in fetch alone and ends with a final fetch; results leave
// one per processed slot, and busy stays high until the tick is done.
// Reset is asynchronous, active low; results are strobed for one cycle and cannot stall.
`default_nettype none
module formation_reference_generator_unit #(
  parameter int MAX_FOLLOWERS = 16,
  parameter int GRID_WIDTH    = 4,
  parameter int ROW_SPACING   = 131072
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire frg_pkg::req_t req_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_addr_i,
  input  wire logic [4:0]    cfg_wdata_i,
  output logic               res_valid_o,
  output frg_pkg::res_t      res_o
);
  import frg_pkg::*;

  localparam int AW  = (MAX_FOLLOWERS > 1) ? $clog2(MAX_FOLLOWERS) : 1;
  localparam int CAP = (MAX_FOLLOWERS < 16) ? MAX_FOLLOWERS : 16;
  localparam logic [4:0] CAP_L = 5'(CAP);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_LOAD, S_RUN} state_e;

  state_e state_q;
  logic [4:0] step_q, n_q, cnt_q, count_q, lslot_q;
  logic twist_q;

  logic signed [31:0] pos_q [3];
  logic signed [15:0] quat_q [4];
  logic signed [31:0] velw_q [3];
  logic signed [31:0] rate_q [3];
  logic signed [31:0] v_q [3];
  logic signed [35:0] t_q [3];
  logic signed [31:0] lam_q [3];
  logic signed [52:0] c_q [3];
  logic signed [67:0] acc_q;
  res_t res_q;
  logic res_valid_q;

  uop_t u;
  logic signed [35:0] a_op;
  logic signed [31:0] b_op;
  logic signed [67:0] prod;
  logic signed [35:0] t_fin;
  logic signed [52:0] c_fin;
  logic signed [31:0] r_fin;
  logic signed [31:0] r_base;
  logic accept, leader_on, skip_n, wr_ok, last_n;
  logic [4:0] n_inc, n_inc2;
  offset_t wr_data, rd_data;

  assign accept    = start && !busy;
  assign leader_on = !lslot_q[4];
  assign skip_n    = leader_on && (n_q == lslot_q);
  assign wr_ok     = accept && (req_i.kind == KIND_OFFSET)
                     && (int'(req_i.slot) < MAX_FOLLOWERS)
                     && !(leader_on && ({1'b0, req_i.slot} == lslot_q));
  assign n_inc     = n_q + 5'd1;
  assign n_inc2    = n_q + 5'd2;
  assign last_n    = (n_inc >= cnt_q)
                     || (n_inc2 == cnt_q && leader_on && lslot_q == n_inc);

  assign wr_data.x = req_i.vec_x;
  assign wr_data.y = req_i.vec_y;
  assign wr_data.z = req_i.vec_z;

  frg_offset_mem #(
    .MAX_FOLLOWERS(MAX_FOLLOWERS),
    .GRID_WIDTH   (GRID_WIDTH),
    .ROW_SPACING  (ROW_SPACING),
    .AW           (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_ok),
    .wr_addr_i(AW'(req_i.slot)),
    .wr_data_i(wr_data),
    .rd_addr_i(AW'(n_q)),
    .rd_data_o(rd_data)
  );

  // Micro-op decode and operand selection
  always_comb begin
    u = uop(step_q);
    case (u.a)
      A_V0:    a_op = 36'(v_q[0]);
      A_V1:    a_op = 36'(v_q[1]);
      A_V2:    a_op = 36'(v_q[2]);
      A_T0:    a_op = t_q[0];
      A_T1:    a_op = t_q[1];
      A_T2:    a_op = t_q[2];
      A_L0:    a_op = 36'(lam_q[0]);
      A_L1:    a_op = 36'(lam_q[1]);
      A_L2:    a_op = 36'(lam_q[2]);
      default: a_op = '0;
    endcase
    case (u.b)
      B_QW:    b_op = 32'(quat_q[0]);
      B_QX:    b_op = 32'(quat_q[1]);
      B_QY:    b_op = 32'(quat_q[2]);
      B_QZ:    b_op = 32'(quat_q[3]);
      B_R0:    b_op = rate_q[0];
      B_R1:    b_op = rate_q[1];
      B_R2:    b_op = rate_q[2];
      default: b_op = '0;
    endcase
    case (u.wb)
      WB_R1:   r_base = v_q[1];
      WB_R2:   r_base = v_q[2];
      default: r_base = v_q[0];
    endcase
  end

  // Shared multiplier and rounding of the accumulator
  assign prod  = a_op * b_op;
  assign t_fin = 36'((acc_q + 68'sd4096) >>> 13);
  assign c_fin = 53'((acc_q + 68'sd32768) >>> 16);
  assign r_fin = sat32(64'(r_base) + 64'((acc_q + 68'sd8192) >>> 14));

  // Sequencer, leader state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      twist_q     <= 1'b0;
      count_q     <= COUNT_RESET;
      lslot_q     <= LEADER_NONE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      acc_q       <= '0;
      for (int k = 0; k < 3; k++) begin
        pos_q[k]  <= '0;
        velw_q[k] <= '0;
        rate_q[k] <= '0;
        v_q[k]    <= '0;
        t_q[k]    <= '0;
        lam_q[k]  <= '0;
        c_q[k]    <= '0;
      end
      quat_q[0] <= QUAT_ONE;
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
    end else begin
      res_valid_q <= 1'b0;

      // Configuration writes
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_FOLLOWER_COUNT: count_q <= cfg_wdata_i;
          REG_LEADER_SLOT:    lslot_q <= cfg_wdata_i;
          default:            ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (req_i.kind)
              KIND_POSE: begin
                pos_q[0]  <= req_i.vec_x;
                pos_q[1]  <= req_i.vec_y;
                pos_q[2]  <= req_i.vec_z;
                quat_q[0] <= req_i.quat_w;
                quat_q[1] <= req_i.quat_x;
                quat_q[2] <= req_i.quat_y;
                quat_q[3] <= req_i.quat_z;
              end
              KIND_TWIST: begin
                v_q[0]    <= req_i.vec_x;
                v_q[1]    <= req_i.vec_y;
                v_q[2]    <= req_i.vec_z;
                rate_q[0] <= req_i.rate_x;
                rate_q[1] <= req_i.rate_y;
                rate_q[2] <= req_i.rate_z;
                twist_q   <= 1'b1;
                step_q    <= '0;
                state_q   <= S_RUN;
              end
              KIND_TICK: begin
                cnt_q   <= (count_q > CAP_L) ? CAP_L : count_q;
                n_q     <= '0;
                twist_q <= 1'b0;
                state_q <= S_FETCH;
              end
              default: ;
            endcase
          end
        end

        // Skip the leader slot, read the next offset, or end the tick
        S_FETCH: begin
          if (n_q >= cnt_q) begin
            state_q <= S_IDLE;
          end else if (skip_n) begin
            n_q <= n_inc;
          end else begin
            state_q <= S_LOAD;
          end
        end

        S_LOAD: begin
          v_q[0]  <= rd_data.x;
          v_q[1]  <= rd_data.y;
          v_q[2]  <= rd_data.z;
          step_q  <= '0;
          state_q <= S_RUN;
        end

        S_RUN: begin
          step_q <= step_q + 5'd1;
          // multiply-accumulate
          case (u.op)
            OP_LOAD: acc_q <= prod;
            OP_ADD:  acc_q <= acc_q + prod;
            OP_SUB:  acc_q <= acc_q - prod;
            default: ;
          endcase
          // write-back of the previous accumulation
          case (u.wb)
            WB_T0:   t_q[0]   <= t_fin;
            WB_T1:   t_q[1]   <= t_fin;
            WB_T2:   t_q[2]   <= t_fin;
            WB_R0:   lam_q[0] <= r_fin;
            WB_R1:   lam_q[1] <= r_fin;
            WB_R2:   lam_q[2] <= r_fin;
            WB_C0:   c_q[0]   <= c_fin;
            WB_C1:   c_q[1]   <= c_fin;
            WB_C2:   c_q[2]   <= c_fin;
            default: ;
          endcase
          if (twist_q && step_q == STEP_TWIST_DONE) begin
            for (int k = 0; k < 3; k++) begin
              velw_q[k] <= lam_q[k];
            end
            state_q <= S_IDLE;
          end else if (!twist_q && step_q == STEP_EMIT) begin
            res_q.follower <= n_q[3:0];
            res_q.pos_x    <= sat32(64'(pos_q[0]) + 64'(lam_q[0]));
            res_q.pos_y    <= sat32(64'(pos_q[1]) + 64'(lam_q[1]));
            res_q.pos_z    <= sat32(64'(pos_q[2]) + 64'(lam_q[2]));
            res_q.vel_x    <= sat32(64'(velw_q[0]) + 64'(c_q[0]));
            res_q.vel_y    <= sat32(64'(velw_q[1]) + 64'(c_q[1]));
            res_q.vel_z    <= sat32(64'(velw_q[2]) + 64'(c_q[2]));
            res_q.head_w   <= quat_q[0];
            res_q.head_x   <= quat_q[1];
            res_q.head_y   <= quat_q[2];
            res_q.head_z   <= quat_q[3];
            res_q.last     <= last_n;
            res_valid_q    <= 1'b1;
            n_q            <= n_inc;
            state_q        <= S_FETCH;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A result leaves only while a tick is still being worked off
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result strobe outside a tick");

  // Results are spaced by a full slot computation, so strobes never come back to back
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("back-to-back result strobes");

  // A tick or twist request always starts the sequencer
  a_seq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.kind == KIND_TICK || req_i.kind == KIND_TWIST)) |=> busy)
    else $error("sequencer did not start");

endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for the formation reference generator: random and directed requests, predicted results.
`default_nettype none
module tb;
  import frg_pkg::*;

  typedef logic signed [71:0] wide_t;

  // Predicts follower references and holds them until the block emits them
  class formation_predictor;
    wide_t lead_pos[3];
    wide_t lead_quat[4];
    wide_t lead_vel[3];
    wide_t lead_rate[3];
    wide_t offs[16][3];
    int unsigned count;
    int lead_slot;
    res_t pending_refs[$];
    int errors;

    function new();
      errors = 0;
      for (int k = 0; k < 3; k++) begin
        lead_pos[k] = 0; lead_vel[k] = 0; lead_rate[k] = 0;
      end
      lead_quat[0] = 16384; lead_quat[1] = 0; lead_quat[2] = 0; lead_quat[3] = 0;
      for (int i = 0; i < 16; i++) begin
        offs[i][0] = wide_t'((i % 4) * 131072);
        offs[i][1] = wide_t'((i / 4) * 131072);
        offs[i][2] = 0;
      end
      count = 12;
      lead_slot = -1;
    endfunction

    function wide_t rnd(wide_t x, int n);
      wide_t half;
      half = wide_t'(1) <<< (n - 1);
      return (x + half) >>> n;
    endfunction

    function wide_t clamp(wide_t x);
      if (x > wide_t'(64'sd2147483647)) return wide_t'(64'sd2147483647);
      if (x < -wide_t'(64'sd2147483648)) return -wide_t'(64'sd2147483648);
      return x;
    endfunction

    // v' = v + w t + qv x t with t = 2 (qv x v)
    function void spin(input wide_t v[3], output wide_t r[3]);
      wide_t w, qx, qy, qz, t0, t1, t2;
      w = lead_quat[0]; qx = lead_quat[1]; qy = lead_quat[2]; qz = lead_quat[3];
      t0 = rnd(2 * (qy * v[2] - qz * v[1]), 14);
      t1 = rnd(2 * (qz * v[0] - qx * v[2]), 14);
      t2 = rnd(2 * (qx * v[1] - qy * v[0]), 14);
      r[0] = v[0] + rnd(w * t0 + (qy * t2 - qz * t1), 14);
      r[1] = v[1] + rnd(w * t1 + (qz * t0 - qx * t2), 14);
      r[2] = v[2] + rnd(w * t2 + (qx * t1 - qy * t0), 14);
    endfunction

    function void write_reg(logic idx, logic [4:0] val);
      if (idx == REG_FOLLOWER_COUNT) count = 32'(val);
      else lead_slot = 32'($signed(val));
    endfunction

    function void note_request(req_t r);
      wide_t v[3], g[3], lam[3], cr[3];
      int n_max, first;
      res_t e;
      v[0] = wide_t'(r.vec_x); v[1] = wide_t'(r.vec_y); v[2] = wide_t'(r.vec_z);
      case (r.kind)
        KIND_POSE: begin
          for (int k = 0; k < 3; k++) lead_pos[k] = v[k];
          lead_quat[0] = wide_t'(r.quat_w); lead_quat[1] = wide_t'(r.quat_x);
          lead_quat[2] = wide_t'(r.quat_y); lead_quat[3] = wide_t'(r.quat_z);
        end
        KIND_TWIST: begin
          spin(v, lam);
          for (int k = 0; k < 3; k++) lead_vel[k] = clamp(lam[k]);
          lead_rate[0] = wide_t'(r.rate_x);
          lead_rate[1] = wide_t'(r.rate_y);
          lead_rate[2] = wide_t'(r.rate_z);
        end
        KIND_OFFSET: begin
          if (int'(r.slot) != lead_slot)
            for (int k = 0; k < 3; k++) offs[r.slot][k] = v[k];
        end
        default: begin
          n_max = (count > 16) ? 16 : int'(count);
          first = pending_refs.size();
          for (int n = 0; n < n_max; n++) begin
            if (n == lead_slot) continue;
            for (int k = 0; k < 3; k++) g[k] = offs[n][k];
            spin(g, lam);
            for (int k = 0; k < 3; k++) lam[k] = clamp(lam[k]);
            cr[0] = rnd(lead_rate[1] * lam[2] - lead_rate[2] * lam[1], 16);
            cr[1] = rnd(lead_rate[2] * lam[0] - lead_rate[0] * lam[2], 16);
            cr[2] = rnd(lead_rate[0] * lam[1] - lead_rate[1] * lam[0], 16);
            e.follower = 4'(n);
            e.pos_x = 32'(clamp(lead_pos[0] + lam[0]));
            e.pos_y = 32'(clamp(lead_pos[1] + lam[1]));
            e.pos_z = 32'(clamp(lead_pos[2] + lam[2]));
            e.vel_x = 32'(clamp(lead_vel[0] + cr[0]));
            e.vel_y = 32'(clamp(lead_vel[1] + cr[1]));
            e.vel_z = 32'(clamp(lead_vel[2] + cr[2]));
            e.head_w = 16'(lead_quat[0]); e.head_x = 16'(lead_quat[1]);
            e.head_y = 16'(lead_quat[2]); e.head_z = 16'(lead_quat[3]);
            e.last = 1'b0;
            pending_refs.insert(pending_refs.size(), e);
          end
          if (pending_refs.size() > first)
            pending_refs[pending_refs.size() - 1].last = 1'b1;
        end
      endcase
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s expected %0d got %0d", name, $signed(exp_v), $signed(act_v));
        errors++;
      end
    endfunction

    function void check_reference(res_t a);
      res_t e;
      if (pending_refs.size() == 0) begin
        $error("follower reference with none expected, follower %0d", a.follower);
        errors++;
        return;
      end
      e = pending_refs.pop_front();
      cmp("follower", 32'(e.follower), 32'(a.follower));
      cmp("pos_x", e.pos_x, a.pos_x);
      cmp("pos_y", e.pos_y, a.pos_y);
      cmp("pos_z", e.pos_z, a.pos_z);
      cmp("vel_x", e.vel_x, a.vel_x);
      cmp("vel_y", e.vel_y, a.vel_y);
      cmp("vel_z", e.vel_z, a.vel_z);
      cmp("head_w", {{16{e.head_w[15]}}, e.head_w}, {{16{a.head_w[15]}}, a.head_w});
      cmp("head_x", {{16{e.head_x[15]}}, e.head_x}, {{16{a.head_x[15]}}, a.head_x});
      cmp("head_y", {{16{e.head_y[15]}}, e.head_y}, {{16{a.head_y[15]}}, a.head_y});
      cmp("head_z", {{16{e.head_z[15]}}, e.head_z}, {{16{a.head_z[15]}}, a.head_z});
      cmp("last", 32'(e.last), 32'(a.last));
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy, cfg_we_i, cfg_addr_i, res_valid_o;
  logic [4:0] cfg_wdata_i;
  req_t req_i;
  res_t res_o;
  formation_predictor pred;

  formation_reference_generator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) pred.check_reference(res_o);
  end

  // Fields: extremes, small values or fully random
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2) == 0 ? 32'd0 : 32'hffffffff;
      3: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 32768)) - 16'd16384;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int sel;
    r.slot = 4'($urandom_range(0, 15));
    r.vec_x = pick32(); r.vec_y = pick32(); r.vec_z = pick32();
    r.quat_w = pick16(); r.quat_x = pick16(); r.quat_y = pick16(); r.quat_z = pick16();
    r.rate_x = pick32(); r.rate_y = pick32(); r.rate_z = pick32();
    sel = $urandom_range(0, 9);
    if (sel < 2) r.kind = KIND_POSE;
    else if (sel < 4) r.kind = KIND_TWIST;
    else if (sel < 7) r.kind = KIND_OFFSET;
    else r.kind = KIND_TICK;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 80);
  endfunction

  // Issue one request, waiting until the block takes it, then idle for the gap given
  task automatic send(req_t r, int gap);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred.note_request(r);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pred.pending_refs.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Registers are written only with the block idle
  task automatic configure(logic [4:0] cnt, logic [4:0] lslot);
    drain();
    cfg_we_i <= 1'b1; cfg_addr_i <= REG_FOLLOWER_COUNT; cfg_wdata_i <= cnt;
    @(posedge clk_i);
    pred.write_reg(REG_FOLLOWER_COUNT, cnt);
    cfg_addr_i <= REG_LEADER_SLOT; cfg_wdata_i <= lslot;
    @(posedge clk_i);
    pred.write_reg(REG_LEADER_SLOT, lslot);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic req_t mk(logic [1:0] kind, logic [3:0] slot, logic [31:0] v,
                              logic [15:0] q);
    req_t r;
    r.kind = kind; r.slot = slot;
    r.vec_x = v; r.vec_y = ~v; r.vec_z = v;
    r.quat_w = q; r.quat_x = ~q; r.quat_y = q; r.quat_z = ~q;
    r.rate_x = v; r.rate_y = ~v; r.rate_z = v;
    return r;
  endfunction

  logic [4:0] counts [8] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd5, 5'd16, 5'd8, 5'd3};
  logic [4:0] slots  [8] = '{5'd15, 5'd3, 5'd15, 5'd0, 5'd3, 5'b10000, 5'd10, 5'b11011};

  initial begin
    pred = new();
    start = 1'b0; req_i = '0; cfg_we_i = 1'b0; cfg_addr_i = 1'b0; cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset grid, extremes, leader-slot writes
    send(mk(KIND_TICK, 4'd0, 32'd0, 16'd0), 0);
    send(mk(KIND_TWIST, 4'd0, 32'h7fffffff, 16'h4000), 0);
    send(mk(KIND_TICK, 4'd0, 32'd0, 16'd0), 3);
    send(mk(KIND_POSE, 4'd0, 32'h7fffffff, 16'h7fff), 0);
    send(mk(KIND_TWIST, 4'd0, 32'h80000000, 16'h0), 0);
    send(mk(KIND_POSE, 4'd0, 32'h80000000, 16'h8000), 0);
    send(mk(KIND_OFFSET, 4'd15, 32'h80000000, 16'h0), 0);
    send(mk(KIND_OFFSET, 4'd0, 32'h7fffffff, 16'h0), 0);
    send(mk(KIND_TICK, 4'd0, 32'd0, 16'd0), 0);
    configure(5'd16, 5'd2);
    send(mk(KIND_OFFSET, 4'd2, 32'h12345678, 16'h0), 0);
    send(mk(KIND_OFFSET, 4'd15, 32'hffffffff, 16'h0), 0);
    send(mk(KIND_POSE, 4'd0, 32'h00010000, 16'h2d41), 0);
    send(mk(KIND_TICK, 4'd0, 32'd0, 16'd0), 0);
    send(mk(KIND_POSE, 4'd0, 32'h00000000, 16'h4000), 0);
    send(mk(KIND_TWIST, 4'd0, 32'h7fffffff, 16'h0), 0);
    send(mk(KIND_TICK, 4'd0, 32'd0, 16'd0), 0);

    // Random phases over several register settings
    for (int p = 0; p < 8; p++) begin
      configure(counts[p], slots[p]);
      for (int i = 0; i < 23; i++) begin
        send(rand_request(), gap_len());
        if (p == 4 && i == 10) drain();
      end
    end

    drain();
    if (pred.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run time guard
  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

// File: formation_reference_generator_unit.f
hdl/frg_pkg.sv
hdl/frg_offset_mem.sv
hdl/formation_reference_generator_unit.sv
sim/tb.sv
